// ===== rtl/lru_pkg.sv =====
// Shared constants and types for the LRU page replacement block.
`default_nettype none
package lru_pkg;

  localparam int FRAME_SLOTS_DEF = 8;
  localparam int PAGE_WIDTH_DEF  = 16;
  localparam int CFG_W           = 4;
  localparam int SLOT_OUT_W      = 3;
  localparam int FAULT_W         = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_HIT,
    OP_FILL,
    OP_REPL
  } op_kind_t;

  // Command broadcast to every cell on a transfer.
  typedef struct packed {
    logic     apply;
    op_kind_t kind;
    logic     clear;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/lru_ref_if.sv =====
// Reference channel: one page reference per transfer.
`default_nettype none
interface lru_ref_if #(
  parameter int PAGE_W = lru_pkg::PAGE_WIDTH_DEF
) ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;
  logic              last_reference;

  modport source (output valid, output page_number, output last_reference, input ready);
  modport sink   (input valid, input page_number, input last_reference, output ready);
endinterface
`default_nettype wire

// ===== rtl/lru_res_if.sv =====
// Result channel: one replacement result per transfer.
`default_nettype none
interface lru_res_if #(
  parameter int PAGE_W = lru_pkg::PAGE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [lru_pkg::SLOT_OUT_W-1:0] frame_slot;
  logic                           replaced_valid;
  logic [PAGE_W-1:0]              replaced_page;
  logic [lru_pkg::FAULT_W-1:0]    fault_total;

  modport source (output valid, output hit, output frame_slot, output replaced_valid,
                  output replaced_page, output fault_total, input ready);
  modport sink   (input valid, input hit, input frame_slot, input replaced_valid,
                  input replaced_page, input fault_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/lru_cell.sv =====
// One frame cell: resident page, valid bit and age rank, with a lookup chain stage.
`default_nettype none
module lru_cell #(
  parameter int FRAME_SLOTS = lru_pkg::FRAME_SLOTS_DEF,
  parameter int PAGE_WIDTH  = lru_pkg::PAGE_WIDTH_DEF,
  parameter int CELL_IDX    = 0
) (
  input  wire                                                      clk,
  input  wire                                                      rst_n,
  input  wire  [PAGE_WIDTH-1:0]                                    lookup_page,
  input  wire  [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] lru_rank,
  // chain from the lower neighbor
  input  wire                                                      hit_in,
  input  wire  [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] hit_idx_in,
  input  wire  [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] hit_rank_in,
  input  wire                                                      lru_in,
  input  wire  [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] lru_idx_in,
  input  wire  [PAGE_WIDTH-1:0]                                    lru_page_in,
  // chain to the upper neighbor
  output logic                                                     hit_out,
  output logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] hit_idx_out,
  output logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] hit_rank_out,
  output logic                                                     lru_out,
  output logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] lru_idx_out,
  output logic [PAGE_WIDTH-1:0]                                    lru_page_out,
  // update command
  input  wire  lru_pkg::cell_cmd_t                                 cmd,
  input  wire  [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] cmd_slot,
  input  wire  [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] cmd_rank,
  input  wire  [PAGE_WIDTH-1:0]                                    cmd_page,
  output logic                                                     slot_valid
);

  localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                  valid_r, valid_nxt;
  logic [IDX_W-1:0]      rank_r, rank_nxt;
  logic [PAGE_WIDTH-1:0] page_r, page_nxt;
  logic                  match;
  logic                  is_lru;
  logic                  target;

  assign match  = valid_r && (page_r == lookup_page);
  assign is_lru = valid_r && (rank_r == lru_rank);
  assign target = (cmd_slot == MY_IDX);

  // Hits and victims are unique among cells, so the chain merges by OR.
  assign hit_out      = hit_in | match;
  assign hit_idx_out  = hit_idx_in | (match ? MY_IDX : '0);
  assign hit_rank_out = hit_rank_in | (match ? rank_r : '0);
  assign lru_out      = lru_in | is_lru;
  assign lru_idx_out  = lru_idx_in | (is_lru ? MY_IDX : '0);
  assign lru_page_out = lru_page_in | (is_lru ? page_r : '0);

  assign slot_valid = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    page_nxt  = page_r;
    if (cmd.apply) begin
      unique case (cmd.kind)
        lru_pkg::OP_HIT: begin
          if (target) begin
            rank_nxt = '0;
          end else if (valid_r && (rank_r < cmd_rank)) begin
            rank_nxt = rank_r + 1'b1;
          end
        end
        lru_pkg::OP_FILL: begin
          if (target) begin
            valid_nxt = 1'b1;
            rank_nxt  = '0;
            page_nxt  = cmd_page;
          end else if (valid_r) begin
            rank_nxt = rank_r + 1'b1;
          end
        end
        lru_pkg::OP_REPL: begin
          if (target) begin
            rank_nxt = '0;
            page_nxt = cmd_page;
          end else if (valid_r) begin
            rank_nxt = rank_r + 1'b1;
          end
        end
        default: begin
          rank_nxt = rank_r;
        end
      endcase
      // drop the string after its last reference
      if (cmd.clear) begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// Top level of the LRU page replacement block: cell chain, fill and fault counters, result register.
//
// Usage:
//   in_ch carries one page reference per transfer (page_number, last_reference).
//   out_ch returns exactly one result per reference: hit, frame_slot,
//   replaced_valid, replaced_page and the saturating fault_total.
//   cfg_we/cfg_wdata set frames_in_use (0 acts as 1, values above the
//   number of frame cells act as that number); write it only while idle.
// Timing:
//   A reference is looked up and all cells are updated in the cycle it
//   transfers; its result appears on out_ch in the next cycle. One
//   reference per cycle is taken while the result register is empty or
//   being drained. The figure is set by the combinational compare and
//   rank update along the chain of frame cells.
// Reset:
//   rst_n (synchronous) empties every frame, clears ranks, fill count and
//   fault count and sets frames_in_use to 8. The same clearing, but for
//   frames_in_use, happens after a reference marked last_reference.
// Stall:
//   While out_ch is held off, the result stays in its register and in_ch
//   is not ready until that result transfers.
`default_nettype none
module lru_page_replacement #(
  parameter int FRAME_SLOTS = lru_pkg::FRAME_SLOTS_DEF,
  parameter int PAGE_WIDTH  = lru_pkg::PAGE_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  lru_ref_if.sink                      in_ch,
  lru_res_if.source                    out_ch,
  input  wire                          cfg_we,
  input  wire  [lru_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int IDX_W   = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CNT_W   = $clog2(FRAME_SLOTS + 1);
  localparam int CMP_W   = (CNT_W > lru_pkg::CFG_W) ? CNT_W : lru_pkg::CFG_W;
  localparam int FAULT_W = lru_pkg::FAULT_W;
  localparam int SOUT_W  = lru_pkg::SLOT_OUT_W;

  logic [lru_pkg::CFG_W-1:0] cfg_r, cfg_nxt;
  logic [CNT_W-1:0]          filled_r, filled_nxt;
  logic [FAULT_W-1:0]        fault_r, fault_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      hit_r;
  logic [SOUT_W-1:0]         slot_r;
  logic                      repl_valid_r;
  logic [PAGE_WIDTH-1:0]     repl_page_r;
  logic [FAULT_W-1:0]        fault_out_r;

  logic                      in_ready;
  logic                      accept;

  logic                      hit_c      [FRAME_SLOTS+1];
  logic [IDX_W-1:0]          hit_idx_c  [FRAME_SLOTS+1];
  logic [IDX_W-1:0]          hit_rank_c [FRAME_SLOTS+1];
  logic                      lru_c      [FRAME_SLOTS+1];
  logic [IDX_W-1:0]          lru_idx_c  [FRAME_SLOTS+1];
  logic [PAGE_WIDTH-1:0]     lru_page_c [FRAME_SLOTS+1];
  logic [FRAME_SLOTS-1:0]    valid_vec;

  logic [IDX_W-1:0]          lru_rank;
  logic [lru_pkg::CFG_W-1:0] cfg_eff;
  logic                      fill_ok;
  lru_pkg::cell_cmd_t        cmd;
  logic [IDX_W-1:0]          cmd_slot;
  logic                      is_hit;
  logic [SOUT_W+IDX_W-1:0]   slot_wide;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  assign hit_c[0]      = 1'b0;
  assign hit_idx_c[0]  = '0;
  assign hit_rank_c[0] = '0;
  assign lru_c[0]      = 1'b0;
  assign lru_idx_c[0]  = '0;
  assign lru_page_c[0] = '0;

  // Ranks of the filled cells are a permutation, so the victim has rank filled-1.
  assign lru_rank = IDX_W'(filled_r - CNT_W'(1));

  genvar gi;
  generate
    for (gi = 0; gi < FRAME_SLOTS; gi++) begin : g_cell
      lru_cell #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .PAGE_WIDTH  (PAGE_WIDTH),
        .CELL_IDX    (gi)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_page  (in_ch.page_number),
        .lru_rank     (lru_rank),
        .hit_in       (hit_c[gi]),
        .hit_idx_in   (hit_idx_c[gi]),
        .hit_rank_in  (hit_rank_c[gi]),
        .lru_in       (lru_c[gi]),
        .lru_idx_in   (lru_idx_c[gi]),
        .lru_page_in  (lru_page_c[gi]),
        .hit_out      (hit_c[gi+1]),
        .hit_idx_out  (hit_idx_c[gi+1]),
        .hit_rank_out (hit_rank_c[gi+1]),
        .lru_out      (lru_c[gi+1]),
        .lru_idx_out  (lru_idx_c[gi+1]),
        .lru_page_out (lru_page_c[gi+1]),
        .cmd          (cmd),
        .cmd_slot     (cmd_slot),
        .cmd_rank     (hit_rank_c[FRAME_SLOTS]),
        .cmd_page     (in_ch.page_number),
        .slot_valid   (valid_vec[gi])
      );
    end
  endgenerate

  assign is_hit  = hit_c[FRAME_SLOTS];
  assign cfg_eff = (cfg_r == '0) ? lru_pkg::CFG_W'(1) : cfg_r;
  assign fill_ok = (filled_r < CNT_W'(FRAME_SLOTS)) && (CMP_W'(filled_r) < CMP_W'(cfg_eff));

  always_comb begin
    cmd.apply = accept;
    cmd.clear = in_ch.last_reference;
    priority if (is_hit) begin
      cmd.kind = lru_pkg::OP_HIT;
      cmd_slot = hit_idx_c[FRAME_SLOTS];
    end else if (fill_ok) begin
      cmd.kind = lru_pkg::OP_FILL;
      cmd_slot = filled_r[IDX_W-1:0];
    end else begin
      cmd.kind = lru_pkg::OP_REPL;
      cmd_slot = lru_idx_c[FRAME_SLOTS];
    end
  end

  assign slot_wide = {{SOUT_W{1'b0}}, cmd_slot};

  always_comb begin
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    filled_nxt    = filled_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (!is_hit && (fault_r != {FAULT_W{1'b1}})) begin
        fault_nxt = fault_r + 1'b1;
      end
      if (cmd.kind == lru_pkg::OP_FILL) begin
        filled_nxt = filled_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= lru_pkg::CFG_RESET;
      filled_r    <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && in_ch.last_reference) begin
        filled_r <= '0;
        fault_r  <= '0;
      end else begin
        filled_r <= filled_nxt;
        fault_r  <= fault_nxt;
      end
    end
  end

  // Hold the result payload until the next transfer in.
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r        <= is_hit;
      slot_r       <= slot_wide[SOUT_W-1:0];
      repl_valid_r <= (cmd.kind == lru_pkg::OP_REPL);
      repl_page_r  <= (cmd.kind == lru_pkg::OP_REPL) ? lru_page_c[FRAME_SLOTS] : '0;
      fault_out_r  <= fault_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = hit_r;
  assign out_ch.frame_slot     = slot_r;
  assign out_ch.replaced_valid = repl_valid_r;
  assign out_ch.replaced_page  = repl_page_r;
  assign out_ch.fault_total    = fault_out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(FRAME_SLOTS))
    else $error("fill count beyond frame cells");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(filled_r))
    else $error("valid cells disagree with fill count");

  a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_hit && !fill_ok |-> lru_c[FRAME_SLOTS])
    else $error("replacement without a victim cell");

  a_string_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_reference |=> (filled_r == '0) && (fault_r == '0) && (valid_vec == '0))
    else $error("state not cleared after last reference");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the LRU page replacement block: stimulus, prediction and checks.
`timescale 1ns / 1ps

typedef struct packed {
  logic                              hit;
  logic [lru_pkg::SLOT_OUT_W-1:0]    frame_slot;
  logic                              replaced_valid;
  logic [lru_pkg::PAGE_WIDTH_DEF-1:0] replaced_page;
  logic [lru_pkg::FAULT_W-1:0]       fault_total;
} lru_result_t;

class lru_replacement_tracker;
  localparam int SLOTS = lru_pkg::FRAME_SLOTS_DEF;
  localparam logic [lru_pkg::FAULT_W-1:0] FAULT_MAX = '1;

  logic [lru_pkg::PAGE_WIDTH_DEF-1:0] page_of[SLOTS];
  bit                                 held[SLOTS];
  int                                 rank[SLOTS];
  int                                 filled;
  logic [lru_pkg::FAULT_W-1:0]        faults;
  logic [lru_pkg::CFG_W-1:0]          frame_limit;
  lru_result_t                        expected_q[$];
  int                                 errors;
  int                                 kind_seen[3];
  int                                 strings_done;

  function new();
    frame_limit = lru_pkg::CFG_RESET;
    errors = 0;
    strings_done = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    foreach (page_of[i]) page_of[i] = '0;
    clear_string();
  endfunction

  function void clear_string();
    foreach (held[i]) begin
      held[i] = 0;
      rank[i] = 0;
    end
    filled = 0;
    faults = '0;
  endfunction

  function void set_limit(logic [lru_pkg::CFG_W-1:0] value);
    frame_limit = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Make slot s the youngest; age the valid slots whose rank is below bound.
  function void age_slots(int s, int bound);
    for (int i = 0; i < SLOTS; i++) begin
      if (held[i] && i != s && rank[i] < bound) rank[i]++;
    end
    rank[s] = 0;
  endfunction

  function void note_reference(logic [lru_pkg::PAGE_WIDTH_DEF-1:0] page, logic last);
    lru_result_t     exp;
    lru_pkg::op_kind_t kind;
    int              lim;
    int              s;
    int              oldest;
    bit              found;
    exp = '0;
    s = 0;
    kind = lru_pkg::OP_REPL;
    lim = frame_limit;
    if (lim < 1) lim = 1;
    if (lim > SLOTS) lim = SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (held[i] && page_of[i] == page) begin
        kind = lru_pkg::OP_HIT;
        s = i;
        break;
      end
    end
    if (kind == lru_pkg::OP_HIT) begin
      age_slots(s, rank[s]);
    end else if (filled < lim) begin
      kind = lru_pkg::OP_FILL;
      s = filled;
      held[s] = 1;
      filled++;
      age_slots(s, SLOTS);
    end else begin
      // Evict the oldest among all filled slots, even above a lowered limit.
      found = 0;
      oldest = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (held[i] && (!found || rank[i] > oldest)) begin
          oldest = rank[i];
          s = i;
          found = 1;
        end
      end
      exp.replaced_valid = 1'b1;
      exp.replaced_page = page_of[s];
      age_slots(s, SLOTS);
    end
    if (kind != lru_pkg::OP_HIT) begin
      page_of[s] = page;
      if (faults != FAULT_MAX) faults++;
    end
    exp.hit = (kind == lru_pkg::OP_HIT);
    exp.frame_slot = s[lru_pkg::SLOT_OUT_W-1:0];
    exp.fault_total = faults;
    expected_q.push_back(exp);
    kind_seen[kind]++;
    if (last) begin
      strings_done++;
      clear_string();
    end
  endfunction

  function void compare_field(string field, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, exp, got);
      errors++;
    end
  endfunction

  function void check_result(lru_result_t got);
    lru_result_t exp;
    if (expected_q.size() == 0) begin
      $display("%0t ns: result with nothing pending, expected none, actual %0h", $time, got);
      errors++;
      return;
    end
    exp = expected_q.pop_front();
    compare_field("hit", exp.hit, got.hit);
    compare_field("frame_slot", exp.frame_slot, got.frame_slot);
    compare_field("replaced_valid", exp.replaced_valid, got.replaced_valid);
    compare_field("replaced_page", exp.replaced_page, got.replaced_page);
    compare_field("fault_total", exp.fault_total, got.fault_total);
  endfunction
endclass

module tb_top;

  localparam int PW          = lru_pkg::PAGE_WIDTH_DEF;
  localparam int LONG_HOLD   = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int STRING_RUN  = 85;
  localparam int TAIL_RUN    = 60;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [lru_pkg::CFG_W-1:0] cfg_wdata;
  int                        send_gap_odds;
  int                        recv_gap_odds;
  bit                        long_hold_req;
  int                        quiet_cycles;

  lru_ref_if #(.PAGE_W(PW)) ref_ch ();
  lru_res_if #(.PAGE_W(PW)) res_ch ();

  lru_replacement_tracker tracker = new();

  lru_page_replacement #(
    .FRAME_SLOTS(lru_pkg::FRAME_SLOTS_DEF),
    .PAGE_WIDTH (PW)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (ref_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample both channels at the rising edge; watchdog on transfer-free cycles.
  always @(posedge clk) begin : monitor
    lru_result_t got;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        got.hit = res_ch.hit;
        got.frame_slot = res_ch.frame_slot;
        got.replaced_valid = res_ch.replaced_valid;
        got.replaced_page = res_ch.replaced_page;
        got.fault_total = res_ch.fault_total;
        tracker.check_result(got);
      end
      if (ref_ch.valid && ref_ch.ready)
        tracker.note_reference(ref_ch.page_number, ref_ch.last_reference);
      if ((res_ch.valid && res_ch.ready) || (ref_ch.valid && ref_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t ns: no transfer for %0d cycles, giving up", $time, QUIET_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin : receiver
    int gap;
    res_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        res_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 0;
        res_ch.ready = 1'b1;
      end else if (recv_gap_odds != 0 && $urandom_range(1, recv_gap_odds) == 1) begin
        gap = $urandom_range(1, 15);
        res_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // Offer one reference and hold it until the transfer; valid stays high afterwards.
  task automatic send_ref(logic [PW-1:0] page, logic last);
    int gap;
    if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      ref_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    ref_ch.valid = 1'b1;
    ref_ch.page_number = page;
    ref_ch.last_reference = last;
    do @(posedge clk); while (!ref_ch.ready);
  endtask

  // Drain the block, then write the frame limit.
  task automatic write_frame_limit(logic [lru_pkg::CFG_W-1:0] value);
    @(negedge clk);
    ref_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_limit(value);
  endtask

  // Reference strings with a small working set around a random base, some noise mixed in.
  task automatic run_strings(int n_items);
    int          sent;
    int          len;
    int          spread;
    logic [PW-1:0] base;
    logic [PW-1:0] page;
    logic        last;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 40);
      spread = $urandom_range(1, 12);
      base = PW'($urandom);
      for (int k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(0, 9) == 0) page = PW'($urandom);
        else page = base + PW'($urandom_range(0, spread - 1));
        // Leave some strings open so state carries into the next limit.
        last = (k == len - 1) && ($urandom_range(0, 4) != 0);
        send_ref(page, last);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [lru_pkg::CFG_W-1:0] limits[12];
    limits = '{4'd1, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd0, 4'd7, 4'd4, 4'd6, 4'd12, 4'd9};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    ref_ch.valid = 1'b0;
    ref_ch.page_number = '0;
    ref_ch.last_reference = 1'b0;
    send_gap_odds = 0;
    recv_gap_odds = 0;
    long_hold_req = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Page extremes, a hit, then fills at the reset limit.
    send_ref('0, 1'b0);
    send_ref('1, 1'b0);
    send_ref('0, 1'b0);
    send_ref(PW'(1), 1'b0);
    send_ref(PW'(2), 1'b0);
    send_ref(PW'(3), 1'b0);
    // Lower the limit under five filled slots; the string continues.
    write_frame_limit(4'd2);
    send_ref(PW'(4), 1'b0);
    send_ref(PW'(1), 1'b0);
    send_ref(PW'(5), 1'b1);
    // Zero frames behaves as one.
    write_frame_limit(4'd0);
    send_ref(PW'(7), 1'b0);
    send_ref(PW'(7), 1'b0);
    send_ref(PW'(8), 1'b0);
    send_ref(PW'(9), 1'b1);
    // Above the slot count behaves as the full set; fill, then evict.
    write_frame_limit(4'd15);
    for (int i = 10; i < 18; i++) send_ref(PW'(i), 1'b0);
    send_ref(PW'(18), 1'b0);
    send_ref(PW'(10), 1'b1);

    foreach (limits[p]) begin
      write_frame_limit(limits[p]);
      case ($urandom_range(0, 2))
        0: send_gap_odds = 0;
        1: send_gap_odds = 3;
        default: send_gap_odds = 8;
      endcase
      case ($urandom_range(0, 2))
        0: recv_gap_odds = 0;
        1: recv_gap_odds = 3;
        default: recv_gap_odds = 8;
      endcase
      if (p == 2) long_hold_req = 1;
      run_strings(STRING_RUN);
    end

    // Final stretch at full rate: one string of distinct pages, fills then evictions.
    send_gap_odds = 0;
    recv_gap_odds = 0;
    write_frame_limit(4'd8);
    for (int n = 0; n < TAIL_RUN; n++) send_ref(PW'(n), n == TAIL_RUN - 1);

    @(negedge clk);
    ref_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d hits, %0d fills and %0d evictions over %0d reference strings.",
             tracker.kind_seen[lru_pkg::OP_HIT], tracker.kind_seen[lru_pkg::OP_FILL],
             tracker.kind_seen[lru_pkg::OP_REPL], tracker.strings_done);
    $display("Frame limits from 0 to 15 used, with receiver stalls and back-to-back transfers.");
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lru_pkg.sv
rtl/lru_ref_if.sv
rtl/lru_res_if.sv
rtl/lru_cell.sv
rtl/lru_page_replacement.sv
tb/tb_top.sv
